FILE: rtl/spike_window_threshold_decoder_macros.svh
// assertion macros for the spike window threshold decoder
`ifndef SPIKE_WINDOW_THRESHOLD_DECODER_MACROS_SVH
`define SPIKE_WINDOW_THRESHOLD_DECODER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SWTD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the trigger
`define SWTD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swtd_pkg.sv
// shared types and constants of the spike window threshold decoder
package swtd_pkg;

  // parameter defaults
  localparam int MAX_WINDOW_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int SPIKE_W  = 8;
  localparam int CODE_W   = 2;
  localparam int WLEN_W   = 6;
  localparam int KEY_W    = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int BIN_W    = 16;
  localparam int OUT_CNT_W = 16;
  // history entry: expected code, channel b, channel a
  localparam int HIST_W   = CODE_W + 2 * SPIKE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_KEY_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_KEY_B   = 2'd2;

  // motor codes
  localparam logic [CODE_W-1:0] MOTOR_NONE = 2'd0;
  localparam logic [CODE_W-1:0] MOTOR_LOW  = 2'd1;
  localparam logic [CODE_W-1:0] MOTOR_MID  = 2'd2;
  localparam logic [CODE_W-1:0] MOTOR_HIGH = 2'd3;

  // scoring codes
  localparam logic [CODE_W-1:0] SUCC_MISS     = 2'd0;
  localparam logic [CODE_W-1:0] SUCC_HIT      = 2'd1;
  localparam logic [CODE_W-1:0] SUCC_UNSCORED = 2'd2;
  localparam logic [CODE_W-1:0] EXP_UNSCORED  = 2'd0;

  // control of the window accumulator
  typedef struct packed {
    logic clear;
    logic add;
    logic use_first;
  } acc_ctrl_t;

endpackage

FILE: rtl/spike_window_threshold_decoder.sv
// top level: sequencer, scoring counters and output register of the decoder
//
//   channel | ports                                   | handshake
//   in      | spike_a, spike_b, expected_motor, last  | in_valid / in_ready
//   out     | motor_code, success, counts, last       | out_valid / out_ready
//   cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// An accepted bin is stored in the history memory, then each result walks the window
// through the shared accumulator: the L taps, then the expected code read, each one
// passing through the memory's registered read port, then the output register.
// The walk is serial because the history memory has a single read port.
// A bin that yields no result is only stored; a final bin yields up to (L + 1) / 2.
// in_ready is high only when no bin is in progress; out_ready low holds the result
// in the output register and the next walk. Reset is synchronous and active low.
`include "spike_window_threshold_decoder_macros.svh"

module spike_window_threshold_decoder #(
  parameter int MAX_WINDOW = swtd_pkg::MAX_WINDOW_DEF,
  parameter int COUNT_BITS = swtd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [swtd_pkg::SPIKE_W-1:0]   in_spike_a,
  input  logic [swtd_pkg::SPIKE_W-1:0]   in_spike_b,
  input  logic [swtd_pkg::CODE_W-1:0]    in_expected_motor,
  input  logic                           in_last_bin,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swtd_pkg::CODE_W-1:0]    out_motor_code,
  output logic [swtd_pkg::CODE_W-1:0]    out_success,
  output logic [swtd_pkg::OUT_CNT_W-1:0] out_hit_count,
  output logic [swtd_pkg::OUT_CNT_W-1:0] out_scored_count,
  output logic                           out_last_result,
  // configuration port
  input  logic                           cfg_we,
  input  logic [swtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swtd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int TAP_W  = $clog2(MAX_WINDOW + 2);
  localparam int OFF_W  = AW + 2;
  localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);
  localparam int QW     = SUM_W + 2;
  localparam int WL_X   = 7;
  localparam int SPW    = swtd_pkg::SPIKE_W;
  localparam int CW     = swtd_pkg::CODE_W;
  localparam int BW     = swtd_pkg::BIN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [BW-1:0]         BIN_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [swtd_pkg::WLEN_W-1:0] wlen_r;
  logic [swtd_pkg::KEY_W-1:0]  key_a_r, key_b_r;

  // trial state
  logic [AW-1:0]         wr_slot_r, wr_slot_nxt;
  logic [BW-1:0]         bin_count_r, bin_count_nxt;
  logic [SPW-1:0]        first_a_r, first_a_nxt;
  logic [SPW-1:0]        first_b_r, first_b_nxt;
  logic [COUNT_BITS-1:0] hits_r, hits_nxt;
  logic [COUNT_BITS-1:0] scored_r, scored_nxt;

  // per-bin walk state
  logic [AW-1:0]    cur_slot_r, cur_slot_nxt;
  logic [BW-1:0]    n_r, n_nxt;
  logic             last_r, last_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             d_tap_r, d_tap_nxt;
  logic             d_first_r, d_first_nxt;
  logic             d_ex_r, d_ex_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [CW-1:0]                  out_motor_r, out_motor_nxt;
  logic [CW-1:0]                  out_succ_r, out_succ_nxt;
  logic [swtd_pkg::OUT_CNT_W-1:0] out_hit_r, out_hit_nxt;
  logic [swtd_pkg::OUT_CNT_W-1:0] out_scored_r, out_scored_nxt;
  logic                           out_last_r, out_last_nxt;

  // datapath wires
  logic                        in_beat, out_beat;
  logic [WL_X-1:0]             wl_ext, len_sel;
  logic [LEN_W-1:0]            len_in, right_in, left_cur;
  logic [AW-1:0]               k_first;
  logic                        emit_start;
  logic                        issue, is_ex_tap, use_first_now;
  logic [OFF_W-1:0]            base_w, tap_w, off_w;
  logic [AW-1:0]               rd_off;
  logic [AW:0]                 slot_sum;
  logic [AW-1:0]               rd_addr;
  logic [swtd_pkg::HIST_W-1:0] mem_wdata, mem_rdata;
  swtd_pkg::acc_ctrl_t         acc_ctrl;
  logic                        acc_clear;
  logic [SUM_W-1:0]            sum_a, sum_b, s1, s2;
  logic [QW-1:0]               q1, q2, qlen;
  logic [CW-1:0]               motor, rd_ex, succ;
  logic                        counts_clear;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid_r && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= swtd_pkg::WLEN_W'(1);
      key_a_r <= '0;
      key_b_r <= swtd_pkg::KEY_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        swtd_pkg::REG_WINDOW_LENGTH: wlen_r  <= cfg_wdata[swtd_pkg::WLEN_W-1:0];
        swtd_pkg::REG_ORDER_KEY_A:   key_a_r <= cfg_wdata;
        swtd_pkg::REG_ORDER_KEY_B:   key_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective window length and its right half
  always_comb begin
    wl_ext = WL_X'(wlen_r);
    if (wl_ext == '0) begin
      len_sel = WL_X'(1);
    end else if (wl_ext > WL_X'(MAX_WINDOW)) begin
      len_sel = WL_X'(MAX_WINDOW);
    end else begin
      len_sel = wl_ext;
    end
  end
  assign len_in   = len_sel[LEN_W-1:0];
  assign right_in = len_in - (len_in >> 1) - LEN_W'(1);
  assign k_first  = (bin_count_r < BW'(right_in)) ? AW'(bin_count_r) : AW'(right_in);
  assign emit_start = in_last_bin || (bin_count_r >= BW'(right_in));

  // window tap offset back from the newest bin, clamped at zero
  assign left_cur  = len_r >> 1;
  assign issue     = (state_r == ST_WALK) && (tap_r <= TAP_W'(len_r));
  assign is_ex_tap = (tap_r == TAP_W'(len_r));
  assign base_w    = OFF_W'(k_r) + OFF_W'(left_cur);
  assign tap_w     = OFF_W'(tap_r);
  assign off_w     = (tap_w > base_w) ? '0 : (base_w - tap_w);
  assign use_first_now = !is_ex_tap && (BW'(off_w) > n_r);
  assign rd_off    = is_ex_tap ? k_r : off_w[AW-1:0];

  // ring slot behind the newest bin
  assign slot_sum = (AW+1)'(cur_slot_r) + (AW+1)'(MAX_WINDOW) - (AW+1)'(rd_off);
  assign rd_addr  = (slot_sum >= (AW+1)'(MAX_WINDOW)) ?
                    AW'(slot_sum - (AW+1)'(MAX_WINDOW)) : AW'(slot_sum);

  assign mem_wdata = {in_expected_motor, in_spike_b, in_spike_a};

  swtd_hist_mem #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (in_beat),
    .waddr (wr_slot_r),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  assign acc_ctrl.clear     = acc_clear;
  assign acc_ctrl.add       = d_tap_r;
  assign acc_ctrl.use_first = d_first_r;

  swtd_window_unit #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .mem_a   (mem_rdata[SPW-1:0]),
    .mem_b   (mem_rdata[2*SPW-1:SPW]),
    .first_a (first_a_r),
    .first_b (first_b_r),
    .sum_a   (sum_a),
    .sum_b   (sum_b)
  );

  // channel order and quarter thresholds, tested as 4*sum against length
  assign s1   = (key_b_r < key_a_r) ? sum_b : sum_a;
  assign s2   = (key_b_r < key_a_r) ? sum_a : sum_b;
  assign q1   = {s1, 2'b00};
  assign q2   = {s2, 2'b00};
  assign qlen = QW'(len_r);
  assign rd_ex = mem_rdata[swtd_pkg::HIST_W-1:2*SPW];

  always_comb begin
    if (q2 < qlen && q1 < qlen) begin
      motor = swtd_pkg::MOTOR_LOW;
    end else if (q2 >= qlen && q1 <= qlen) begin
      motor = swtd_pkg::MOTOR_MID;
    end else if (q2 >= qlen && q1 > qlen) begin
      motor = swtd_pkg::MOTOR_HIGH;
    end else begin
      motor = swtd_pkg::MOTOR_NONE;
    end
  end

  always_comb begin
    if (rd_ex == swtd_pkg::EXP_UNSCORED) begin
      succ = swtd_pkg::SUCC_UNSCORED;
    end else if (motor == rd_ex) begin
      succ = swtd_pkg::SUCC_HIT;
    end else begin
      succ = swtd_pkg::SUCC_MISS;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    wr_slot_nxt    = wr_slot_r;
    bin_count_nxt  = bin_count_r;
    first_a_nxt    = first_a_r;
    first_b_nxt    = first_b_r;
    hits_nxt       = hits_r;
    scored_nxt     = scored_r;
    cur_slot_nxt   = cur_slot_r;
    n_nxt          = n_r;
    last_nxt       = last_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    tap_nxt        = tap_r;
    d_tap_nxt      = issue && !is_ex_tap;
    d_first_nxt    = issue && use_first_now;
    d_ex_nxt       = issue && is_ex_tap;
    out_valid_nxt  = out_valid_r;
    out_motor_nxt  = out_motor_r;
    out_succ_nxt   = out_succ_r;
    out_hit_nxt    = out_hit_r;
    out_scored_nxt = out_scored_r;
    out_last_nxt   = out_last_r;
    acc_clear      = 1'b0;
    if (issue) begin
      tap_nxt = tap_r + TAP_W'(1);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          // store the bin and advance the trial
          if (bin_count_r == '0) begin
            first_a_nxt = in_spike_a;
            first_b_nxt = in_spike_b;
          end
          cur_slot_nxt = wr_slot_r;
          wr_slot_nxt  = (wr_slot_r == AW'(MAX_WINDOW - 1)) ? '0 : wr_slot_r + AW'(1);
          n_nxt        = bin_count_r;
          last_nxt     = in_last_bin;
          len_nxt      = len_in;
          if (in_last_bin) begin
            bin_count_nxt = '0;
          end else if (bin_count_r != BIN_MAX) begin
            bin_count_nxt = bin_count_r + BW'(1);
          end
          if (emit_start) begin
            k_nxt     = in_last_bin ? k_first : AW'(right_in);
            tap_nxt   = '0;
            acc_clear = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // expected code arrives after the last tap: score and present
        if (d_ex_r) begin
          out_motor_nxt = motor;
          out_succ_nxt  = succ;
          out_last_nxt  = last_r && (k_r == '0);
          if (rd_ex != swtd_pkg::EXP_UNSCORED) begin
            if (scored_r != COUNT_MAX) begin
              scored_nxt = scored_r + COUNT_BITS'(1);
            end
            if (succ == swtd_pkg::SUCC_HIT && hits_r != COUNT_MAX) begin
              hits_nxt = hits_r + COUNT_BITS'(1);
            end
          end
          out_hit_nxt    = swtd_pkg::OUT_CNT_W'(hits_nxt);
          out_scored_nxt = swtd_pkg::OUT_CNT_W'(scored_nxt);
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_beat) begin
          out_valid_nxt = 1'b0;
          // an ordinary bin gives one result, a final bin drains down to zero
          if (!last_r || k_r == '0) begin
            if (last_r) begin
              hits_nxt   = '0;
              scored_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r - AW'(1);
            tap_nxt   = '0;
            acc_clear = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_slot_r   <= '0;
      bin_count_r <= '0;
      first_a_r   <= '0;
      first_b_r   <= '0;
      hits_r      <= '0;
      scored_r    <= '0;
      d_tap_r     <= 1'b0;
      d_first_r   <= 1'b0;
      d_ex_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      bin_count_r <= bin_count_nxt;
      first_a_r   <= first_a_nxt;
      first_b_r   <= first_b_nxt;
      hits_r      <= hits_nxt;
      scored_r    <= scored_nxt;
      d_tap_r     <= d_tap_nxt;
      d_first_r   <= d_first_nxt;
      d_ex_r      <= d_ex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    cur_slot_r   <= cur_slot_nxt;
    n_r          <= n_nxt;
    last_r       <= last_nxt;
    len_r        <= len_nxt;
    k_r          <= k_nxt;
    tap_r        <= tap_nxt;
    out_motor_r  <= out_motor_nxt;
    out_succ_r   <= out_succ_nxt;
    out_hit_r    <= out_hit_nxt;
    out_scored_r <= out_scored_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_motor_code   = out_motor_r;
  assign out_success      = out_succ_r;
  assign out_hit_count    = out_hit_r;
  assign out_scored_count = out_scored_r;
  assign out_last_result  = out_last_r;

  // both running counts back at zero
  assign counts_clear = (hits_r == '0) && (scored_r == '0);

  // checks
  `SWTD_ASSERT_ALWAYS(a_ready_excl, !(in_ready && out_valid), "input taken while result pending")
  `SWTD_ASSERT_ALWAYS(a_hits_le_scored, hits_r <= scored_r, "hit count above scored count")
  `SWTD_ASSERT_NEXT(a_trial_clear, out_beat && out_last_r, counts_clear, "counts not cleared")

endmodule

FILE: rtl/swtd_hist_mem.sv
// history ring memory: one write port, one registered read port
module swtd_hist_mem #(
  parameter int DEPTH = swtd_pkg::MAX_WINDOW_DEF,
  parameter int AW    = $clog2(swtd_pkg::MAX_WINDOW_DEF)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [swtd_pkg::HIST_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [swtd_pkg::HIST_W-1:0] rdata
);

  logic [swtd_pkg::HIST_W-1:0] mem [DEPTH];
  logic [swtd_pkg::HIST_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/swtd_window_unit.sv
// shared accumulator that sums both channels over the window taps
module swtd_window_unit #(
  parameter int SUM_W = 13
) (
  input  logic                         clk,
  input  swtd_pkg::acc_ctrl_t          ctrl,
  input  logic [swtd_pkg::SPIKE_W-1:0] mem_a,
  input  logic [swtd_pkg::SPIKE_W-1:0] mem_b,
  input  logic [swtd_pkg::SPIKE_W-1:0] first_a,
  input  logic [swtd_pkg::SPIKE_W-1:0] first_b,
  output logic [SUM_W-1:0]             sum_a,
  output logic [SUM_W-1:0]             sum_b
);

  logic [SUM_W-1:0]             sum_a_r, sum_a_nxt;
  logic [SUM_W-1:0]             sum_b_r, sum_b_nxt;
  logic [swtd_pkg::SPIKE_W-1:0] tap_a, tap_b;

  // pick stored bin or clamped front bin
  assign tap_a = ctrl.use_first ? first_a : mem_a;
  assign tap_b = ctrl.use_first ? first_b : mem_b;

  // one add per channel per tap
  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (ctrl.clear) begin
      sum_a_nxt = '0;
      sum_b_nxt = '0;
    end else if (ctrl.add) begin
      sum_a_nxt = sum_a_r + SUM_W'(tap_a);
      sum_b_nxt = sum_b_r + SUM_W'(tap_b);
    end
  end

  always_ff @(posedge clk) begin
    sum_a_r <= sum_a_nxt;
    sum_b_r <= sum_b_nxt;
  end

  assign sum_a = sum_a_r;
  assign sum_b = sum_b_r;

endmodule

FILE: bench/swtd_decode_checker.sv
// checker for the spike window decoder: predicts every result beat and compares it
module swtd_decode_checker #(
  parameter int MAX_WINDOW = swtd_pkg::MAX_WINDOW_DEF,
  parameter int COUNT_BITS = swtd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [swtd_pkg::SPIKE_W-1:0]   in_spike_a,
  input  logic [swtd_pkg::SPIKE_W-1:0]   in_spike_b,
  input  logic [swtd_pkg::CODE_W-1:0]    in_expected_motor,
  input  logic                           in_last_bin,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [swtd_pkg::CODE_W-1:0]    out_motor_code,
  input  logic [swtd_pkg::CODE_W-1:0]    out_success,
  input  logic [swtd_pkg::OUT_CNT_W-1:0] out_hit_count,
  input  logic [swtd_pkg::OUT_CNT_W-1:0] out_scored_count,
  input  logic                           out_last_result,
  input  logic                           cfg_we,
  input  logic [swtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swtd_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             outstanding,
  output int                             fail_count,
  output int                             beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPIKE_W   = swtd_pkg::SPIKE_W;
  localparam int CODE_W    = swtd_pkg::CODE_W;
  localparam int OUT_CNT_W = swtd_pkg::OUT_CNT_W;
  localparam int WLEN_W    = swtd_pkg::WLEN_W;
  localparam int KEY_W     = swtd_pkg::KEY_W;

  localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int unsigned     BIN_MAX   = (1 << swtd_pkg::BIN_W) - 1;
  localparam int              SHOW_MAX  = 10;

  typedef struct packed {
    logic [CODE_W-1:0]    motor;
    logic [CODE_W-1:0]    success;
    logic [OUT_CNT_W-1:0] hits;
    logic [OUT_CNT_W-1:0] scored;
    logic                 last;
  } decode_beat_t;

  // decoded beats still owed by the block, oldest first
  decode_beat_t decoded_q[$];

  // shadow of the block's registers and trial state
  logic [WLEN_W-1:0]  win_len_reg;
  logic [KEY_W-1:0]   key_a_reg;
  logic [KEY_W-1:0]   key_b_reg;
  logic [SPIKE_W-1:0] ring_a   [MAX_WINDOW];
  logic [SPIKE_W-1:0] ring_b   [MAX_WINDOW];
  logic [CODE_W-1:0]  ring_exp [MAX_WINDOW];
  logic [SPIKE_W-1:0] first_a;
  logic [SPIKE_W-1:0] first_b;
  int unsigned        bins_in_trial;
  int unsigned        wr_slot;
  longint unsigned    hit_tally;
  longint unsigned    scored_tally;

  int n_fail;
  int n_checked;

  // ring slot a given number of bins behind the newest one
  function automatic int unsigned ring_back(int unsigned off);
    return (wr_slot + MAX_WINDOW - (off % MAX_WINDOW)) % MAX_WINDOW;
  endfunction

  // window length after the zero and upper limits
  function automatic int unsigned window_bins();
    int unsigned len;
    len = win_len_reg;
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    return len;
  endfunction

  // centred window sums, thresholds and scoring for the bin 'back' places behind
  function automatic void decode_window(int unsigned back, int unsigned len, logic fin);
    int           half_l;
    int           off;
    int unsigned  src;
    int unsigned  sum_a;
    int unsigned  sum_b;
    int unsigned  s1;
    int unsigned  s2;
    logic [CODE_W-1:0] ex_code;
    decode_beat_t beat;
    half_l = len / 2;
    sum_a  = 0;
    sum_b  = 0;
    for (int t = 0; t < int'(len); t++) begin
      off = int'(back) - (t - half_l);
      if (off < 0) off = 0;
      // beyond the trial start: clamp to the first bin
      if (off > int'(bins_in_trial)) begin
        sum_a += first_a;
        sum_b += first_b;
      end else begin
        src = ring_back(off);
        sum_a += ring_a[src];
        sum_b += ring_b[src];
      end
    end
    if (key_b_reg < key_a_reg) begin
      s1 = sum_b;
      s2 = sum_a;
    end else begin
      s1 = sum_a;
      s2 = sum_b;
    end
    // quarter threshold kept exact as 4*sum against the length
    if (4 * s2 < len && 4 * s1 < len) beat.motor = swtd_pkg::MOTOR_LOW;
    else if (4 * s2 >= len && 4 * s1 <= len) beat.motor = swtd_pkg::MOTOR_MID;
    else if (4 * s2 >= len && 4 * s1 > len) beat.motor = swtd_pkg::MOTOR_HIGH;
    else beat.motor = swtd_pkg::MOTOR_NONE;
    ex_code = ring_exp[ring_back(back)];
    if (ex_code == swtd_pkg::EXP_UNSCORED) begin
      beat.success = swtd_pkg::SUCC_UNSCORED;
    end else begin
      beat.success = (beat.motor == ex_code) ? swtd_pkg::SUCC_HIT : swtd_pkg::SUCC_MISS;
      if (scored_tally < TALLY_MAX) scored_tally++;
      if (beat.success == swtd_pkg::SUCC_HIT && hit_tally < TALLY_MAX) hit_tally++;
    end
    beat.hits   = hit_tally[OUT_CNT_W-1:0];
    beat.scored = scored_tally[OUT_CNT_W-1:0];
    beat.last   = fin;
    decoded_q.push_back(beat);
  endfunction

  // store one accepted bin and queue the beats it releases
  function automatic void take_bin(logic [SPIKE_W-1:0] a, logic [SPIKE_W-1:0] b,
                                   logic [CODE_W-1:0] ex, logic last);
    int unsigned len;
    int unsigned right;
    int unsigned n;
    int          k;
    len   = window_bins();
    right = len - len / 2 - 1;
    n     = bins_in_trial;
    if (n == 0) begin
      first_a = a;
      first_b = b;
    end
    ring_a[wr_slot]   = a;
    ring_b[wr_slot]   = b;
    ring_exp[wr_slot] = ex;
    if (last) begin
      // final bin drains every bin still waiting for its right half
      k = (n < right) ? n : right;
      while (k >= 0) begin
        decode_window(k, len, k == 0);
        k--;
      end
    end else if (n >= right) begin
      decode_window(right, len, 1'b0);
    end
    wr_slot = (wr_slot + 1) % MAX_WINDOW;
    if (last) begin
      bins_in_trial = 0;
      hit_tally     = 0;
      scored_tally  = 0;
    end else if (bins_in_trial < BIN_MAX) begin
      bins_in_trial++;
    end
  endfunction

  // watch all three ports at each edge
  always @(posedge clk) begin : watch
    decode_beat_t want;
    logic         bad;
    if (!rst_n) begin
      win_len_reg   = WLEN_W'(1);
      key_a_reg     = '0;
      key_b_reg     = KEY_W'(1);
      first_a       = '0;
      first_b       = '0;
      bins_in_trial = 0;
      wr_slot       = 0;
      hit_tally     = 0;
      scored_tally  = 0;
      n_fail        = 0;
      n_checked     = 0;
      decoded_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        n_checked++;
        if (decoded_q.size() == 0) begin
          if (n_fail < SHOW_MAX) begin
            $write("%0t unexpected result beat: ", $realtime);
            $display("motor %0d success %0d hits %0d scored %0d last %0b",
                     out_motor_code, out_success, out_hit_count,
                     out_scored_count, out_last_result);
          end
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          bad  = 1'b0;
          if (out_motor_code !== want.motor) bad = 1'b1;
          if (out_success !== want.success) bad = 1'b1;
          if (out_hit_count !== want.hits) bad = 1'b1;
          if (out_scored_count !== want.scored) bad = 1'b1;
          if (out_last_result !== want.last) bad = 1'b1;
          if (bad) begin
            if (n_fail < SHOW_MAX) begin
              $write("%0t mismatch: exp motor %0d success %0d hits %0d scored %0d last %0b,",
                     $realtime, want.motor, want.success, want.hits, want.scored,
                     want.last);
              $display(" got motor %0d success %0d hits %0d scored %0d last %0b",
                       out_motor_code, out_success, out_hit_count,
                       out_scored_count, out_last_result);
            end
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready)
        take_bin(in_spike_a, in_spike_b, in_expected_motor, in_last_bin);
      if (cfg_we) begin
        case (cfg_index)
          swtd_pkg::REG_WINDOW_LENGTH: win_len_reg = cfg_wdata[WLEN_W-1:0];
          swtd_pkg::REG_ORDER_KEY_A:   key_a_reg   = cfg_wdata[KEY_W-1:0];
          swtd_pkg::REG_ORDER_KEY_B:   key_b_reg   = cfg_wdata[KEY_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding   <= decoded_q.size();
    fail_count    <= n_fail;
    beats_checked <= n_checked;
  end

endmodule

FILE: bench/tb_spike_window_threshold_decoder.sv
// testbench top: drives bins and registers into the decoder and reports the verdict
module tb_spike_window_threshold_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPIKE_W   = swtd_pkg::SPIKE_W;
  localparam int CODE_W    = swtd_pkg::CODE_W;
  localparam int OUT_CNT_W = swtd_pkg::OUT_CNT_W;
  localparam int CFG_IDX_W = swtd_pkg::CFG_IDX_W;
  localparam int CFG_W     = swtd_pkg::CFG_W;
  localparam int WLEN_W    = swtd_pkg::WLEN_W;
  localparam int KEY_W     = swtd_pkg::KEY_W;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_SETTINGS    = 7;
  localparam int BINS_PER_SETTING = 10;
  localparam int SETTLE_CYCLES    = 48;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SPIKE_W-1:0]   in_spike_a;
  logic [SPIKE_W-1:0]   in_spike_b;
  logic [CODE_W-1:0]    in_expected_motor;
  logic                 in_last_bin;
  logic                 out_valid;
  logic                 out_ready;
  logic [CODE_W-1:0]    out_motor_code;
  logic [CODE_W-1:0]    out_success;
  logic [OUT_CNT_W-1:0] out_hit_count;
  logic [OUT_CNT_W-1:0] out_scored_count;
  logic                 out_last_result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int outstanding;
  int fail_count;
  int beats_checked;

  int bins_sent     = 0;
  int trials_sent   = 0;
  int settings_used = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  spike_window_threshold_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_spike_a        (in_spike_a),
    .in_spike_b        (in_spike_b),
    .in_expected_motor (in_expected_motor),
    .in_last_bin       (in_last_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_code    (out_motor_code),
    .out_success       (out_success),
    .out_hit_count     (out_hit_count),
    .out_scored_count  (out_scored_count),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  swtd_decode_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_spike_a        (in_spike_a),
    .in_spike_b        (in_spike_b),
    .in_expected_motor (in_expected_motor),
    .in_last_bin       (in_last_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_code    (out_motor_code),
    .out_success       (out_success),
    .out_hit_count     (out_hit_count),
    .out_scored_count  (out_scored_count),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .outstanding       (outstanding),
    .fail_count        (fail_count),
    .beats_checked     (beats_checked)
  );

  // spike counts biased towards the quarter threshold, full range now and then
  function automatic logic [SPIKE_W-1:0] draw_spike();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return SPIKE_W'($urandom_range(0, 1));
      2:       return SPIKE_W'($urandom_range(0, 3));
      default: return SPIKE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one input beat after a random gap
  task automatic send_bin(input logic [SPIKE_W-1:0] a, input logic [SPIKE_W-1:0] b,
                          input logic [CODE_W-1:0] ex, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_spike_a        <= a;
    in_spike_b        <= b;
    in_expected_motor <= ex;
    in_last_bin       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bins_sent++;
    if (last) trials_sent++;
  endtask

  // hold off until every predicted beat has arrived and the block is quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || !in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers, junk in the unused upper length bits and unused index
  task automatic set_regs(input logic [WLEN_W-1:0] len, input logic [KEY_W-1:0] ka,
                          input logic [KEY_W-1:0] kb);
    cfg_we    <= 1'b1;
    cfg_index <= swtd_pkg::REG_WINDOW_LENGTH;
    cfg_wdata <= {2'($urandom_range(0, 3)), len};
    @(posedge clk);
    cfg_index <= swtd_pkg::REG_ORDER_KEY_A;
    cfg_wdata <= ka;
    @(posedge clk);
    cfg_index <= swtd_pkg::REG_ORDER_KEY_B;
    cfg_wdata <= kb;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: random stall before each beat
  initial begin : rx_side
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [WLEN_W-1:0] len;
    logic [KEY_W-1:0]  ka;
    logic [KEY_W-1:0]  kb;
    int                end_odds;
    logic              last;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_spike_a        <= '0;
    in_spike_b        <= '0;
    in_expected_motor <= swtd_pkg::EXP_UNSCORED;
    in_last_bin       <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= swtd_pkg::REG_WINDOW_LENGTH;
    cfg_wdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: length one, keys in raw order
    send_bin(8'd0,   8'd0,   swtd_pkg::MOTOR_LOW,    1'b0);
    send_bin(8'd255, 8'd0,   swtd_pkg::EXP_UNSCORED, 1'b0);
    send_bin(8'd0,   8'd255, swtd_pkg::MOTOR_MID,    1'b0);
    send_bin(8'd255, 8'd255, swtd_pkg::MOTOR_HIGH,   1'b1);

    // zero length taken as one, tied keys keep raw order
    drain_and_settle();
    set_regs(WLEN_W'(0), 8'd0, 8'd0);
    send_bin(8'd1, 8'd0, swtd_pkg::MOTOR_LOW, 1'b0);
    send_bin(8'd0, 8'd1, swtd_pkg::MOTOR_MID, 1'b1);

    // oversize length clipped to the ring, swapped channels, one-bin trial
    drain_and_settle();
    set_regs(WLEN_W'(63), 8'd255, 8'd0);
    send_bin(8'd200, 8'd3,   swtd_pkg::MOTOR_MID,    1'b1);
    send_bin(8'd255, 8'd255, swtd_pkg::MOTOR_HIGH,   1'b0);
    send_bin(8'd0,   8'd0,   swtd_pkg::MOTOR_LOW,    1'b0);
    send_bin(8'd128, 8'd1,   swtd_pkg::MOTOR_MID,    1'b0);
    send_bin(8'd1,   8'd128, swtd_pkg::EXP_UNSCORED, 1'b0);
    send_bin(8'd0,   8'd0,   swtd_pkg::MOTOR_HIGH,   1'b1);

    // even length, sums right on the quarter boundary
    drain_and_settle();
    set_regs(WLEN_W'(4), 8'd7, 8'd7);
    send_bin(8'd1, 8'd0, swtd_pkg::MOTOR_MID,  1'b0);
    send_bin(8'd0, 8'd0, swtd_pkg::MOTOR_LOW,  1'b0);
    send_bin(8'd0, 8'd1, swtd_pkg::MOTOR_HIGH, 1'b0);
    send_bin(8'd0, 8'd0, swtd_pkg::MOTOR_MID,  1'b0);
    send_bin(8'd0, 8'd0, swtd_pkg::MOTOR_LOW,  1'b0);
    send_bin(8'd1, 8'd1, swtd_pkg::MOTOR_LOW,  1'b1);

    // odd length with a swap
    drain_and_settle();
    set_regs(WLEN_W'(5), 8'd20, 8'd10);
    send_bin(8'd1, 8'd0, swtd_pkg::MOTOR_LOW,  1'b0);
    send_bin(8'd0, 8'd2, swtd_pkg::MOTOR_MID,  1'b0);
    send_bin(8'd0, 8'd0, swtd_pkg::MOTOR_HIGH, 1'b0);
    send_bin(8'd1, 8'd1, swtd_pkg::MOTOR_NONE, 1'b1);

    // random settings; trials run across setting changes on purpose
    for (int s = 0; s < RAND_SETTINGS; s++) begin
      drain_and_settle();
      case ($urandom_range(0, 3))
        0:       len = WLEN_W'($urandom_range(0, 63));
        1:       len = WLEN_W'($urandom_range(1, 4));
        default: len = WLEN_W'($urandom_range(1, 32));
      endcase
      if (s == 0) len = WLEN_W'(swtd_pkg::MAX_WINDOW_DEF);
      if (s == 1) len = WLEN_W'(1);
      ka = KEY_W'($urandom);
      kb = ($urandom_range(0, 2) == 0) ? ka : KEY_W'($urandom);
      set_regs(len, ka, kb);
      case (s % 3)
        0:       end_odds = 3;
        1:       end_odds = 8;
        default: end_odds = 40;
      endcase
      for (int i = 0; i < BINS_PER_SETTING; i++) begin
        last = ($urandom_range(1, end_odds) == 1) ||
               (s == RAND_SETTINGS - 1 && i == BINS_PER_SETTING - 1);
        send_bin(draw_spike(), draw_spike(), CODE_W'($urandom_range(0, 3)), last);
      end
    end

    // widest window over a longer trial
    drain_and_settle();
    set_regs(WLEN_W'(swtd_pkg::MAX_WINDOW_DEF), 8'd3, 8'd9);
    for (int i = 0; i < 20; i++)
      send_bin(draw_spike(), draw_spike(), CODE_W'($urandom_range(0, 3)), i == 19);

    // wind down
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("covered %0d bins in %0d trials over %0d register settings, %0d result beats",
             bins_sent, trials_sent, settings_used, beats_checked);
    $display("incl. reset values, lengths zero to 63, swapped and tied keys, final-bin drains");
    if (fail_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("timeout: decoder stopped making progress");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/swtd_pkg.sv
rtl/swtd_hist_mem.sv
rtl/swtd_window_unit.sv
rtl/spike_window_threshold_decoder.sv
bench/swtd_decode_checker.sv
bench/tb_spike_window_threshold_decoder.sv
